[sv/qvr_pkg.sv]
// qvr_pkg: shared widths, types and register codes for the quaternion vector rotator
// used by every module of the rotator; depends on nothing
package qvr_pkg;

  // field widths
  localparam int VEC_W   = 24;
  localparam int QUAT_W  = 16;
  localparam int FRAC_W  = 15;

  // internal widths: q*v products, 3-term sums, rounded first product,
  // p*q products, 4-term sums, rounded rotated components
  localparam int PROD1_W = VEC_W + QUAT_W;
  localparam int SUM1_W  = PROD1_W + 2;
  localparam int P_W     = SUM1_W - FRAC_W;
  localparam int PROD2_W = P_W + QUAT_W;
  localparam int SUM2_W  = PROD2_W + 2;
  localparam int R_W     = SUM2_W - FRAC_W;

  localparam int TDATA_W = 3 * VEC_W;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [QUAT_W-1:0]  qc_t;
  typedef logic signed [PROD1_W-1:0] prod1_t;
  typedef logic signed [SUM1_W-1:0]  sum1_t;
  typedef logic signed [P_W-1:0]     pval_t;
  typedef logic signed [PROD2_W-1:0] prod2_t;
  typedef logic signed [SUM2_W-1:0]  sum2_t;
  typedef logic signed [R_W-1:0]     rval_t;

  typedef struct packed {
    qc_t w;
    qc_t x;
    qc_t y;
    qc_t z;
  } quat_t;

  typedef struct packed {
    vec_t z;
    vec_t y;
    vec_t x;
  } vec3_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } cfg_reg_t;

  localparam qc_t QUAT_W_RST = qc_t'(32767);

  // round-half-up offsets
  localparam sum1_t RND1 = sum1_t'(2 ** (FRAC_W - 1));
  localparam sum2_t RND2 = sum2_t'(2 ** (FRAC_W - 1));

  // output clip limits
  localparam rval_t R_MAX = rval_t'(2 ** (VEC_W - 1) - 1);
  localparam rval_t R_MIN = -R_MAX - rval_t'(1);

endpackage

[sv/qvr_fwd.sv]
// qvr_fwd: first Hamilton product p = q * (0,v), two register stages
// stage one holds the twelve q*v products, stage two the rounded p; uses qvr_pkg
module qvr_fwd
  import qvr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  vec3_t vec,
  input  quat_t quat,
  output logic  out_valid,
  output pval_t p0,
  output pval_t p1,
  output pval_t p2,
  output pval_t p3
);

  logic   s1_valid;
  prod1_t xvx, yvy, zvz, wvx, yvz, zvy, wvy, xvz, zvx, wvz, xvy, yvx;
  sum1_t  sum0, sum1, sum2, sum3;

  // stage one: product bank
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      xvx <= prod1_t'(quat.x) * prod1_t'(vec.x);
      yvy <= prod1_t'(quat.y) * prod1_t'(vec.y);
      zvz <= prod1_t'(quat.z) * prod1_t'(vec.z);
      wvx <= prod1_t'(quat.w) * prod1_t'(vec.x);
      yvz <= prod1_t'(quat.y) * prod1_t'(vec.z);
      zvy <= prod1_t'(quat.z) * prod1_t'(vec.y);
      wvy <= prod1_t'(quat.w) * prod1_t'(vec.y);
      xvz <= prod1_t'(quat.x) * prod1_t'(vec.z);
      zvx <= prod1_t'(quat.z) * prod1_t'(vec.x);
      wvz <= prod1_t'(quat.w) * prod1_t'(vec.z);
      xvy <= prod1_t'(quat.x) * prod1_t'(vec.y);
      yvx <= prod1_t'(quat.y) * prod1_t'(vec.x);
    end
  end

  // component sums with rounding offset
  always_comb begin
    sum0 = -sum1_t'(xvx) - sum1_t'(yvy) - sum1_t'(zvz) + RND1;
    sum1 =  sum1_t'(wvx) + sum1_t'(yvz) - sum1_t'(zvy) + RND1;
    sum2 =  sum1_t'(wvy) - sum1_t'(xvz) + sum1_t'(zvx) + RND1;
    sum3 =  sum1_t'(wvz) + sum1_t'(xvy) - sum1_t'(yvx) + RND1;
  end

  // stage two: rounded first product
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
    if (en) begin
      p0 <= pval_t'(sum0 >>> FRAC_W);
      p1 <= pval_t'(sum1 >>> FRAC_W);
      p2 <= pval_t'(sum2 >>> FRAC_W);
      p3 <= pval_t'(sum3 >>> FRAC_W);
    end
  end

endmodule

[sv/qvr_conj.sv]
// qvr_conj: second Hamilton product r = p * conj(q), vector part, two register stages
// stage one holds the twelve p*q products, stage two the rounded r; uses qvr_pkg
module qvr_conj
  import qvr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  pval_t p0,
  input  pval_t p1,
  input  pval_t p2,
  input  pval_t p3,
  input  quat_t quat,
  output logic  out_valid,
  output rval_t r1,
  output rval_t r2,
  output rval_t r3
);

  logic   s1_valid;
  prod2_t p0x, p1w, p2z, p3y, p0y, p1z, p2w, p3x, p0z, p1y, p2x, p3w;
  sum2_t  sum1, sum2, sum3;

  // stage one: product bank
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      p0x <= prod2_t'(p0) * prod2_t'(quat.x);
      p1w <= prod2_t'(p1) * prod2_t'(quat.w);
      p2z <= prod2_t'(p2) * prod2_t'(quat.z);
      p3y <= prod2_t'(p3) * prod2_t'(quat.y);
      p0y <= prod2_t'(p0) * prod2_t'(quat.y);
      p1z <= prod2_t'(p1) * prod2_t'(quat.z);
      p2w <= prod2_t'(p2) * prod2_t'(quat.w);
      p3x <= prod2_t'(p3) * prod2_t'(quat.x);
      p0z <= prod2_t'(p0) * prod2_t'(quat.z);
      p1y <= prod2_t'(p1) * prod2_t'(quat.y);
      p2x <= prod2_t'(p2) * prod2_t'(quat.x);
      p3w <= prod2_t'(p3) * prod2_t'(quat.w);
    end
  end

  // component sums with rounding offset
  always_comb begin
    sum1 = -sum2_t'(p0x) + sum2_t'(p1w) - sum2_t'(p2z) + sum2_t'(p3y) + RND2;
    sum2 = -sum2_t'(p0y) + sum2_t'(p1z) + sum2_t'(p2w) - sum2_t'(p3x) + RND2;
    sum3 = -sum2_t'(p0z) - sum2_t'(p1y) + sum2_t'(p2x) + sum2_t'(p3w) + RND2;
  end

  // stage two: rounded rotated components
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
    if (en) begin
      r1 <= rval_t'(sum1 >>> FRAC_W);
      r2 <= rval_t'(sum2 >>> FRAC_W);
      r3 <= rval_t'(sum3 >>> FRAC_W);
    end
  end

endmodule

[sv/qvr_clip.sv]
// qvr_clip: saturates the rotated components to the vector width, output register stage
// flags any clipped component; uses qvr_pkg
module qvr_clip
  import qvr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  rval_t r1,
  input  rval_t r2,
  input  rval_t r3,
  output logic  out_valid,
  output vec3_t rot,
  output logic  sat
);

  vec3_t rot_next;
  logic  hi1, lo1, hi2, lo2, hi3, lo3;

  // range compares
  always_comb begin
    hi1 = (r1 > R_MAX);
    lo1 = (r1 < R_MIN);
    hi2 = (r2 > R_MAX);
    lo2 = (r2 < R_MIN);
    hi3 = (r3 > R_MAX);
    lo3 = (r3 < R_MIN);
    rot_next.x = hi1 ? vec_t'(R_MAX) : (lo1 ? vec_t'(R_MIN) : vec_t'(r1));
    rot_next.y = hi2 ? vec_t'(R_MAX) : (lo2 ? vec_t'(R_MIN) : vec_t'(r2));
    rot_next.z = hi3 ? vec_t'(R_MAX) : (lo3 ? vec_t'(R_MIN) : vec_t'(r3));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      rot <= rot_next;
      sat <= hi1 | lo1 | hi2 | lo2 | hi3 | lo3;
    end
  end

endmodule

[sv/quaternion_vector_rotate.sv]
// Rotates one 3-D vector per word by the configured unit quaternion, v' = q (0,v) q*,
// with round-half-up after each Hamilton product and saturation to 24 bits; the tuser
// bit flags a clipped result. Accepts one word per clock while the output is not stalled;
// an accepted word passes through the two multiplier banks and their rounding adders
// (two stages per product) and then the clip/output register. The whole pipeline holds
// while the output word waits. Write the quaternion only when idle.
// depends on qvr_pkg, qvr_fwd, qvr_conj, qvr_clip
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [QUAT_W-1:0]  cfg_wdata,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // vec_x, vec_y, vec_z
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // rot_x, rot_y, rot_z
  output logic               m_axis_tuser   // saturated
);

  quat_t quat;
  logic  en;
  vec3_t vec;
  logic  fwd_valid, conj_valid;
  pval_t p0, p1, p2, p3;
  rval_t r1, r2, r3;
  vec3_t rot;
  logic  sat;

  // quaternion registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.w <= QUAT_W_RST;
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_QUAT_W: quat.w <= qc_t'(cfg_wdata);
        REG_QUAT_X: quat.x <= qc_t'(cfg_wdata);
        REG_QUAT_Y: quat.y <= qc_t'(cfg_wdata);
        REG_QUAT_Z: quat.z <= qc_t'(cfg_wdata);
      endcase
    end
  end

  // pipeline advance when output register is free or being drained
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;
  assign vec           = vec3_t'(s_axis_tdata);

  qvr_fwd u_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .vec       (vec),
    .quat      (quat),
    .out_valid (fwd_valid),
    .p0        (p0),
    .p1        (p1),
    .p2        (p2),
    .p3        (p3)
  );

  qvr_conj u_conj (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fwd_valid),
    .p0        (p0),
    .p1        (p1),
    .p2        (p2),
    .p3        (p3),
    .quat      (quat),
    .out_valid (conj_valid),
    .r1        (r1),
    .r2        (r2),
    .r3        (r3)
  );

  qvr_clip u_clip (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (conj_valid),
    .r1        (r1),
    .r2        (r2),
    .r3        (r3),
    .out_valid (m_axis_tvalid),
    .rot       (rot),
    .sat       (sat)
  );

  assign m_axis_tdata = TDATA_W'(rot);
  assign m_axis_tuser = sat;

endmodule

[sv/qvr_chk.sv]
// qvr_chk: port-level checks for the quaternion rotator, bound to the top level
// depends on qvr_pkg
module qvr_chk
  import qvr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tuser
);

  localparam vec_t VMAX = vec_t'(R_MAX);
  localparam vec_t VMIN = vec_t'(R_MIN);

  logic s_acc;
  vec_t ox, oy, oz;

  assign s_acc = s_axis_tvalid & s_axis_tready;
  assign ox    = m_axis_tdata[VEC_W-1:0];
  assign oy    = m_axis_tdata[2*VEC_W-1:VEC_W];
  assign oz    = m_axis_tdata[3*VEC_W-1:2*VEC_W];

  // held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // input side is ready exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output drain");

  // an accepted word shows up at the output if the output never stalls meanwhile
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_acc ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

  // clip flag implies a component at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (ox == VMAX || ox == VMIN || oy == VMAX || oy == VMIN || oz == VMAX || oz == VMIN))
    else $error("saturated flag without a clipped component");

  // nothing valid right out of reset
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind quaternion_vector_rotate qvr_chk u_qvr_chk (.*);

[sim/tb_quaternion_vector_rotate.sv]
// tb_quaternion_vector_rotate: self-checking bench for the quaternion vector rotator,
// predicting every output word from its own copy of the quaternion registers
// depends on qvr_pkg and quaternion_vector_rotate
module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT   = 5;
  localparam int SETTLE_CYC = PIPE_LAT + 3;
  localparam int HOLD_CYC   = 120;
  localparam int STALL_LIM  = 2000;
  localparam int MAX_SHOWN  = 10;

  typedef struct {
    vec_t x;
    vec_t y;
    vec_t z;
    logic sat;
  } rot_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = REG_QUAT_W;
  logic [QUAT_W-1:0]  cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // vec_x, vec_y, vec_z
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // rot_x, rot_y, rot_z
  logic               m_axis_tuser;        // saturated

  // bench copy of the quaternion registers
  quat_t     cur_q;
  rot_word_t rot_expect_q[$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  bit        src_idle    = 1'b1;
  bit        sink_idle   = 1'b1;
  bit        hold_req    = 1'b0;

  quaternion_vector_rotate dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // round to nearest, ties toward plus infinity
  function automatic longint round_frac(longint v);
    return (v + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic vec_t clip_vec(longint v, inout logic sat);
    longint hi;
    longint lo;
    hi = (longint'(1) << (VEC_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return vec_t'(hi);
    end
    if (v < lo) begin
      sat = 1'b1;
      return vec_t'(lo);
    end
    return vec_t'(v);
  endfunction

  // q * (0,v) * conj(q), vector part, against the current register copy
  function automatic rot_word_t rotate_vec(logic [TDATA_W-1:0] d);
    longint    vx, vy, vz, w, x, y, z;
    longint    p0, p1, p2, p3;
    rot_word_t r;
    vx = $signed(d[VEC_W-1:0]);
    vy = $signed(d[2*VEC_W-1:VEC_W]);
    vz = $signed(d[3*VEC_W-1:2*VEC_W]);
    w  = cur_q.w;
    x  = cur_q.x;
    y  = cur_q.y;
    z  = cur_q.z;
    p0 = round_frac(-x * vx - y * vy - z * vz);
    p1 = round_frac(w * vx + y * vz - z * vy);
    p2 = round_frac(w * vy - x * vz + z * vx);
    p3 = round_frac(w * vz + x * vy - y * vx);
    r.sat = 1'b0;
    r.x = clip_vec(round_frac(-p0 * x + p1 * w - p2 * z + p3 * y), r.sat);
    r.y = clip_vec(round_frac(-p0 * y + p1 * z + p2 * w - p3 * x), r.sat);
    r.z = clip_vec(round_frac(-p0 * z - p1 * y + p2 * x + p3 * w), r.sat);
    return r;
  endfunction

  // prediction on input accept, comparison on output accept, stall watchdog
  always @(posedge clk) begin
    rot_word_t got;
    rot_word_t want;
    bit        in_acc;
    bit        out_acc;
    in_acc  = !rst && s_axis_tvalid && s_axis_tready;
    out_acc = !rst && m_axis_tvalid && m_axis_tready;
    if (in_acc)
      rot_expect_q.push_back(rotate_vec(s_axis_tdata));
    if (out_acc) begin
      got.x   = m_axis_tdata[VEC_W-1:0];
      got.y   = m_axis_tdata[2*VEC_W-1:VEC_W];
      got.z   = m_axis_tdata[3*VEC_W-1:2*VEC_W];
      got.sat = m_axis_tuser;
      if (rot_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected output word x=%0d y=%0d z=%0d sat=%b",
                   $realtime, got.x, got.y, got.z, got.sat);
      end else begin
        want = rot_expect_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.sat !== want.sat) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%b got x=%0d y=%0d z=%0d sat=%b",
                     $realtime, want.x, want.y, want.z, want.sat,
                     got.x, got.y, got.z, got.sat);
        end
      end
    end
    if (rst || in_acc || out_acc)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIM) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIM);
      $display("tb_quaternion_vector_rotate failed");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one vector and wait for accept; valid stays high unless a gap follows
  task automatic send_vec(input int vx, input int vy, input int vz);
    s_axis_tdata  <= {vec_t'(vz), vec_t'(vy), vec_t'(vx)};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // end of a burst: wait for every expected word, then let the pipe settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (rot_expect_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // write all four quaternion registers back to back, only while idle
  task automatic load_quat(input quat_t q);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_QUAT_W;
    cfg_wdata <= q.w;
    @(posedge clk);
    cfg_idx   <= REG_QUAT_X;
    cfg_wdata <= q.x;
    @(posedge clk);
    cfg_idx   <= REG_QUAT_Y;
    cfg_wdata <= q.y;
    @(posedge clk);
    cfg_idx   <= REG_QUAT_Z;
    cfg_wdata <= q.z;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_q = q;
  endtask

  function automatic quat_t make_quat(input int w, input int x, input int y, input int z);
    quat_t q;
    q.w = qc_t'(w);
    q.x = qc_t'(x);
    q.y = qc_t'(y);
    q.z = qc_t'(z);
    return q;
  endfunction

  // random direction on the unit sphere in 4-d, scaled to Q1.15
  function automatic quat_t rand_unit_quat;
    real a[4];
    real n;
    do begin
      n = 0.0;
      foreach (a[i]) begin
        a[i] = real'(int'($urandom_range(0, 65534)) - 32767);
        n += a[i] * a[i];
      end
      n = $sqrt(n);
    end while (n < 1000.0);
    return make_quat($rtoi(a[0] * 32767.0 / n), $rtoi(a[1] * 32767.0 / n),
                     $rtoi(a[2] * 32767.0 / n), $rtoi(a[3] * 32767.0 / n));
  endfunction

  task automatic send_rand_vec;
    if ($urandom_range(0, 3) == 0)
      send_vec(int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000,
               int'($urandom_range(0, 4000)) - 2000);
    else
      send_vec(int'($urandom), int'($urandom), int'($urandom));
  endtask

  // reset quaternion: field extremes and rounding ties
  task automatic test_identity_extremes;
    send_vec(0, 0, 0);
    send_vec(8388607, 8388607, 8388607);
    send_vec(-8388608, -8388608, -8388608);
    send_vec(8388607, -8388608, 0);
    send_vec(16384, -16384, 32768);
    send_vec(1, -1, -16385);
    send_vec(-32768, 16383, 49152);
    drain();
  endtask

  // register extremes, non-normalized quaternions and output saturation
  task automatic test_register_extremes;
    load_quat(make_quat(-32768, -32768, -32768, -32768));
    send_vec(8388607, 8388607, 8388607);
    send_vec(-8388608, 8388607, -8388608);
    send_vec(100, -100, 5);
    drain();
    // half turn about x
    load_quat(make_quat(0, 32767, 0, 0));
    send_vec(8388607, -8388608, 12345);
    send_vec(-1, 1, 16384);
    drain();
    load_quat(make_quat(32767, -32768, 32767, -32768));
    send_vec(-8388608, -8388608, 8388607);
    send_vec(4096, -7, 65536);
    drain();
    load_quat(make_quat(0, 0, 0, 0));
    send_vec(8388607, -8388608, 777);
    drain();
  endtask

  // random unit rotations, one raw quaternion mixed in
  task automatic test_random_rotations;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4)
        load_quat(make_quat(int'($urandom), int'($urandom), int'($urandom), int'($urandom)));
      else
        load_quat(rand_unit_quat());
      repeat (80) send_rand_vec();
      drain();
    end
  endtask

  // output held off for a long stretch while input keeps coming
  task automatic test_output_backpressure;
    load_quat(rand_unit_quat());
    src_idle = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_rand_vec();
    drain();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    load_quat(rand_unit_quat());
    repeat (100) send_rand_vec();
    drain();
  endtask

  initial begin
    cur_q = make_quat(QUAT_W_RST, 0, 0, 0);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_identity_extremes();
    test_register_extremes();
    test_random_rotations();
    test_output_backpressure();
    test_full_rate();
    if (rot_expect_q.size() != 0)
      mismatches++;
    if (mismatches == 0)
      $display("tb_quaternion_vector_rotate passed");
    else
      $display("tb_quaternion_vector_rotate failed");
    $finish;
  end

endmodule
